@@ hw/rtl/fwc_pkg.sv @@
// shared types and constants of the framewise window convolution core
// no dependencies

package fwc_pkg;

  // weight format: unsigned q1.16
  localparam int COEF_W    = 17;
  localparam int FRAC_BITS = 16;

  // saturating count of frames seen so far
  localparam int FRAMES_W  = 6;

  // configuration register index width
  localparam int CFG_IDX_W = 1;

  // input item kinds
  localparam logic MODE_COEF   = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_PER_FRAME = 1'b1;

  // control from the tap sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;  // start a new sum
    logic en;     // operands carry a live tap
  } mac_ctrl_t;

endpackage

@@ hw/rtl/fwc_ram.sv @@
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies

module fwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/fwc_mac.sv @@
// shared multiply-accumulate unit with q16 rounding and saturation
// depends on fwc_pkg

module fwc_mac
  import fwc_pkg::*;
#(
  parameter int SAMPLE_BITS = 24,
  parameter int MAX_TAPS    = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mac_ctrl_t                     ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic        [COEF_W-1:0]      weight_i,
  output logic                          busy_o,
  output logic signed [SAMPLE_BITS-1:0] result_o
);

  localparam int TAP_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int PROD_W = SAMPLE_BITS + COEF_W + 1;
  localparam int ACC_W  = PROD_W + TAP_W;
  localparam int RND_W  = ACC_W + 1;
  localparam int SH_W   = RND_W - FRAC_BITS;

  localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [SH_W-1:0]  SAT_MAX  = SH_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam logic signed [SH_W-1:0]  SAT_MIN  = ~SAT_MAX;

  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [RND_W-1:0]  rnd;
  logic signed [SH_W-1:0]   shifted;

  // weight is unsigned, so it enters the signed product with a zero on top
  assign prod_d = sample_i * $signed({1'b0, weight_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.en;
      if (ctrl_i.clear) begin
        acc_q <= '0;
      end else if (prod_vld_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // floor((acc + half) / 2^16), halves round up
  assign rnd     = RND_W'(acc_q) + RND_HALF;
  assign shifted = SH_W'(rnd >>> FRAC_BITS);

  always_comb begin
    if (shifted > SAT_MAX) begin
      result_o = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (shifted < SAT_MIN) begin
      result_o = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      result_o = shifted[SAMPLE_BITS-1:0];
    end
  end

  assign busy_o = prod_vld_q;

endmodule

@@ hw/rtl/framewise_window_convolution_core.sv @@
// top level of the framewise window convolution core: sequencer, stores, output register
// depends on fwc_pkg, fwc_ram and fwc_mac

// Smooths every bin of a frame stream along time with a centered FIR window of
// L = window_length frames (1..MAX_TAPS). A frame is bins_per_frame samples in
// a row. Each bin keeps its last MAX_TAPS-1 samples in a ring inside one history
// ram, and a per-bin fill count makes never-written history read as zero, so
// there is no clearing pass after reset. Weights are loaded with mode 0 items
// into a small weight ram (a load gives no result). A mode 1 sample then
// passes through the sequencer states in order: S_META to fetch the ring
// pointer of its bin, S_TAPS in which the single shared multiplier takes
// one tap each (oldest frame first, the incoming sample last), S_DRAIN to
// empty the read and multiply pipeline (shorter when the incoming sample is
// missing), S_OUT to hand the rounded, saturated sum to the output register
// and finally S_IDLE, the state in which
// the next item can transfer. The tap loop sets the rate; a result that is
// ready while the previous one still waits in the output register holds the
// sequencer and stalls the input. Missing samples, in history or incoming,
// add nothing. Results start once L - L/2 frames have begun, and a flush is
// (L-1)/2 zero frames fed by the user. The output register lets the next
// input transfer while a result still waits under out_stall_i.

module framewise_window_convolution_core
  import fwc_pkg::*;
#(
  parameter int MAX_TAPS    = 32,
  parameter int MAX_BINS    = 256,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [((($clog2(MAX_TAPS+1)) > ($clog2(MAX_BINS+1))) ?
                 $clog2(MAX_TAPS+1) : $clog2(MAX_BINS+1))-1:0] cfg_data_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_value_i,
  input  logic                          sample_missing_i,
  input  logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] coef_index_i,
  input  logic [COEF_W-1:0]             coef_value_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] filtered_value_o,
  output logic [((MAX_BINS > 1) ? $clog2(MAX_BINS) : 1)-1:0] bin_index_o,
  output logic                          frame_end_o
);

  localparam int TAP_W      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int WL_W       = $clog2(MAX_TAPS + 1);
  localparam int NB_W       = $clog2(MAX_BINS + 1);
  localparam int BIN_W      = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CFG_W      = (WL_W > NB_W) ? WL_W : NB_W;
  localparam int HIST_DEPTH = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
  localparam int SLOT_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
  localparam int META_W     = SLOT_W + CNT_W;
  localparam int HADDR_W    = SLOT_W + BIN_W;
  localparam int HIST_W     = SAMPLE_BITS + 1;
  localparam int CMP_W      = NB_W + 1;
  localparam int FR_W       = ((FRAMES_W > WL_W) ? FRAMES_W : WL_W) + 1;
  localparam int D_W        = WL_W + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_META  = 5'b00010,
    S_TAPS  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [WL_W-1:0] wl_q;
  logic [NB_W-1:0] nb_q;

  // stream position
  logic [BIN_W-1:0]    bin_q;
  logic [FRAMES_W-1:0] frames_q;

  // item under work
  logic [WL_W-1:0]              l_q;
  logic [BIN_W-1:0]             b_q;
  logic                         last_q, emit_q, miss_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [SLOT_W-1:0]            ptr_q;
  logic [CNT_W-1:0]             cnt_q;
  logic [TAP_W-1:0]             tap_q;

  // read stage of the tap pipeline
  logic s1_vld_q, s1_hist_q, s1_live_q;

  // per-bin ring state has a valid bit so unwritten bins read as empty
  logic [MAX_BINS-1:0] meta_vld_q;

  // output register
  logic                          out_valid_q, out_end_q;
  logic signed [SAMPLE_BITS-1:0] out_value_q;
  logic [BIN_W-1:0]              out_bin_q;

  logic accept, acc_sample, acc_coef, coef_ok, out_free, load_out;
  logic [WL_W-1:0]  l_eff, thr, l_m1, tap_ext, age;
  logic [NB_W-1:0]  n_eff, n_m1;
  logic             last_cur, emit_cur;
  logic [BIN_W-1:0] b_cur;

  logic [META_W-1:0] meta_rdata;
  logic              meta_we;
  logic [SLOT_W-1:0] ptr_eff, ptr_nx;
  logic [CNT_W-1:0]  cnt_eff, cnt_nx;

  logic [D_W-1:0]    diff;
  logic [SLOT_W-1:0] slot;
  logic              tap_is_hist, tap_live, tap_done;

  logic [HIST_W-1:0] hist_rdata;
  logic              hist_we, drain_done;
  logic [COEF_W-1:0] weight_rdata;

  mac_ctrl_t                     mac_ctrl;
  logic signed [SAMPLE_BITS-1:0] mac_sample;
  logic                          mac_skip, mac_busy;
  logic signed [SAMPLE_BITS-1:0] mac_result;

  // ---------------------------------------------------------------------------
  // handshake and per-item decode
  // ---------------------------------------------------------------------------

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign acc_sample = accept && (mode_i == MODE_SAMPLE);
  assign acc_coef   = accept && (mode_i == MODE_COEF);
  assign coef_ok    = (TAP_W + 1)'(coef_index_i) < (TAP_W + 1)'(MAX_TAPS);

  // out-of-range register values fold onto the nearest legal one
  always_comb begin
    l_eff = wl_q;
    if (wl_q == '0) begin
      l_eff = WL_W'(1);
    end else if (wl_q > WL_W'(MAX_TAPS)) begin
      l_eff = WL_W'(MAX_TAPS);
    end
    n_eff = nb_q;
    if (nb_q == '0) begin
      n_eff = NB_W'(1);
    end else if (nb_q > NB_W'(MAX_BINS)) begin
      n_eff = NB_W'(MAX_BINS);
    end
  end

  // a position at or past the frame end is taken as the last bin
  assign n_m1     = n_eff - NB_W'(1);
  assign last_cur = (CMP_W'(bin_q) + CMP_W'(1)) >= CMP_W'(n_eff);
  assign b_cur    = last_cur ? n_m1[BIN_W-1:0] : bin_q;

  // results start once L - L/2 frames have begun
  assign thr      = l_eff - (l_eff >> 1);
  assign emit_cur = (FR_W'(frames_q) + FR_W'(1)) >= FR_W'(thr);

  // ---------------------------------------------------------------------------
  // configuration and stream position
  // ---------------------------------------------------------------------------

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q     <= WL_W'(1);
      nb_q     <= NB_W'(MAX_BINS);
      bin_q    <= '0;
      frames_q <= '0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == CFG_WINDOW_LENGTH)) begin
        wl_q <= cfg_data_i[WL_W-1:0];
      end
      if (cfg_we_i && (cfg_idx_i == CFG_BINS_PER_FRAME)) begin
        nb_q <= cfg_data_i[NB_W-1:0];
      end
      if (acc_sample) begin
        if (last_cur) begin
          bin_q <= '0;
          if (frames_q != '1) begin
            frames_q <= frames_q + FRAMES_W'(1);
          end
        end else begin
          bin_q <= bin_q + BIN_W'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // per-bin ring pointer and fill count
  // ---------------------------------------------------------------------------

  fwc_ram #(
    .WIDTH (META_W),
    .DEPTH (MAX_BINS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (b_q),
    .wdata_i ({ptr_nx, cnt_nx}),
    .raddr_i (b_cur),
    .rdata_o (meta_rdata)
  );

  assign meta_we = (state_q == S_META);
  assign ptr_eff = meta_vld_q[b_q] ? meta_rdata[META_W-1:CNT_W] : '0;
  assign cnt_eff = meta_vld_q[b_q] ? meta_rdata[CNT_W-1:0] : '0;
  assign ptr_nx  = (ptr_eff == SLOT_W'(HIST_DEPTH - 1)) ? '0 : ptr_eff + SLOT_W'(1);
  assign cnt_nx  = (cnt_eff == CNT_W'(HIST_DEPTH)) ? cnt_eff : cnt_eff + CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_vld_q <= '0;
    end else if (meta_we) begin
      meta_vld_q[b_q] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // tap addressing: tap i reads the entry of age L-1-i, the last tap is the
  // incoming sample; the newest stored entry sits just below the write slot
  // ---------------------------------------------------------------------------

  assign l_m1        = l_q - WL_W'(1);
  assign tap_ext     = WL_W'(tap_q);
  assign age         = l_m1 - tap_ext;
  assign tap_done    = (tap_ext == l_m1);
  assign tap_is_hist = !tap_done;
  assign tap_live    = age <= WL_W'(cnt_q);

  always_comb begin
    diff = D_W'(ptr_q) - D_W'(age);
    if (diff[D_W-1]) begin
      diff = diff + D_W'(HIST_DEPTH);
    end
  end
  assign slot = diff[SLOT_W-1:0];

  // sample history: value with its missing flag
  fwc_ram #(
    .WIDTH (HIST_W),
    .DEPTH (2 ** HADDR_W)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i ({ptr_q, b_q}),
    .wdata_i ({miss_q, sample_q}),
    .raddr_i ({slot, b_q}),
    .rdata_o (hist_rdata)
  );

  // weights, undefined until loaded
  fwc_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_TAPS)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (acc_coef && coef_ok),
    .waddr_i (coef_index_i),
    .wdata_i (coef_value_i),
    .raddr_i (tap_q),
    .rdata_o (weight_rdata)
  );

  // ---------------------------------------------------------------------------
  // shared multiply-accumulate
  // ---------------------------------------------------------------------------

  assign mac_sample = s1_hist_q ? $signed(hist_rdata[SAMPLE_BITS-1:0]) : sample_q;
  assign mac_skip   = s1_hist_q ? (!s1_live_q || hist_rdata[HIST_W-1]) : miss_q;

  assign mac_ctrl.clear = acc_sample;
  assign mac_ctrl.en    = s1_vld_q && !mac_skip;

  fwc_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_TAPS    (MAX_TAPS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .sample_i (mac_sample),
    .weight_i (weight_rdata),
    .busy_o   (mac_busy),
    .result_o (mac_result)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------

  assign drain_done = (state_q == S_DRAIN) && !s1_vld_q && !mac_busy;
  // the write slot holds the oldest entry, read as the first tap, so overwrite only after
  assign hist_we    = drain_done;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (state_q == S_OUT) && emit_q && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc_sample) begin
          state_d = S_META;
        end
      end
      S_META: begin
        state_d = S_TAPS;
      end
      S_TAPS: begin
        if (tap_done) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (drain_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!emit_q || out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      s1_vld_q <= 1'b0;
      tap_q    <= '0;
    end else begin
      state_q  <= state_d;
      s1_vld_q <= (state_q == S_TAPS);
      if (state_q == S_META) begin
        tap_q <= '0;
      end else if ((state_q == S_TAPS) && !tap_done) begin
        tap_q <= tap_q + TAP_W'(1);
      end
    end
  end

  // item payload, held for the whole sequence
  always_ff @(posedge clk_i) begin
    if (acc_sample) begin
      l_q      <= l_eff;
      b_q      <= b_cur;
      last_q   <= last_cur;
      emit_q   <= emit_cur;
      sample_q <= sample_value_i;
      miss_q   <= sample_missing_i;
    end
    if (state_q == S_META) begin
      ptr_q <= ptr_eff;
      cnt_q <= cnt_eff;
    end
    s1_hist_q <= tap_is_hist;
    s1_live_q <= tap_live;
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_value_q <= mac_result;
      out_bin_q   <= b_q;
      out_end_q   <= last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = out_value_q;
  assign bin_index_o      = out_bin_q;
  assign frame_end_o      = out_end_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // products only come from taps issued by this item's sequence
  a_mac_in_sequence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_busy |-> (state_q == S_TAPS || state_q == S_DRAIN))
    else $error("multiplier active outside the tap sequence");

  // the tap counter stays inside the window
  a_tap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAPS) |-> (WL_W'(tap_q) < l_q))
    else $error("tap counter past window length");

  // a sample transfer always starts a busy sequence
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_sample |=> in_stall_o)
    else $error("sample transfer did not start the sequencer");

  // the frame counter only counts up
  a_frames_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frames_q >= $past(frames_q))
    else $error("frame counter went down");

endmodule

@@ tb/sv/tb.sv @@
// self-checking testbench for framewise_window_convolution_core
// depends on fwc_pkg and the core rtl; holds its own bin-wise smoothing predictor
`timescale 1ns / 1ps

typedef struct {
  logic               mode;
  logic signed [23:0] value;
  logic               missing;
  logic [4:0]         coef_idx;
  logic [16:0]        coef_val;
} smooth_item_t;

typedef struct {
  logic signed [23:0] value;
  logic [7:0]         bin;
  logic               frame_end;
} smoothed_t;

// predicts the smoothed bins and checks the core's results in order
class bin_smoother_sb;
  localparam int TAPS = 32;
  localparam int BINS = 256;

  logic [16:0]        weight    [TAPS];
  logic signed [23:0] past_val  [TAPS][BINS];
  bit                 past_miss [TAPS][BINS];
  logic [7:0]         bin_pos;
  logic [5:0]         frames_seen;
  logic [5:0]         wlen;
  logic [8:0]         nbins;
  smoothed_t          pending_smoothed [$];
  int                 mismatches;
  int                 checked;

  function new();
    foreach (weight[i]) weight[i] = '0;
    foreach (past_val[k, b]) begin
      past_val[k][b]  = '0;
      past_miss[k][b] = 1'b0;
    end
    bin_pos     = '0;
    frames_seen = '0;
    wlen        = 6'd1;
    nbins       = 9'd256;
    mismatches  = 0;
    checked     = 0;
  endfunction

  function int unsigned taps();
    int unsigned t;
    t = wlen;
    if (t < 1) t = 1;
    if (t > TAPS) t = TAPS;
    return t;
  endfunction

  function int unsigned frame_bins();
    int unsigned n;
    n = nbins;
    if (n < 1) n = 1;
    if (n > BINS) n = BINS;
    return n;
  endfunction

  function int pending();
    return pending_smoothed.size();
  endfunction

  function void set_reg(logic [fwc_pkg::CFG_IDX_W-1:0] idx, logic [8:0] data);
    if (idx == fwc_pkg::CFG_WINDOW_LENGTH) wlen = data[5:0];
    else nbins = data;
  endfunction

  function void note_item(smooth_item_t it);
    int unsigned L, N, slot, row;
    bit          last, emit;
    longint      acc, rounded;
    smoothed_t   r;
    if (it.mode == fwc_pkg::MODE_COEF) begin
      weight[it.coef_idx] = it.coef_val;
      return;
    end
    L    = taps();
    N    = frame_bins();
    last = (bin_pos + 1 >= N);
    slot = last ? N - 1 : bin_pos;
    // stored frames oldest first, the incoming bin takes the last tap
    acc = 0;
    for (int i = 0; i + 1 < L; i++) begin
      row = TAPS - (L - 1) + i;
      if (!past_miss[row][slot])
        acc += longint'(past_val[row][slot]) * longint'({1'b0, weight[i]});
    end
    if (!it.missing)
      acc += longint'(it.value) * longint'({1'b0, weight[L-1]});
    for (int k = 1; k + 1 < TAPS; k++) begin
      past_val[k][slot]  = past_val[k+1][slot];
      past_miss[k][slot] = past_miss[k+1][slot];
    end
    past_val[TAPS-1][slot]  = it.value;
    past_miss[TAPS-1][slot] = it.missing;
    // round half up, then clip to the sample range
    rounded = (acc + 32768) >>> 16;
    if (rounded > 64'sd8388607) rounded = 64'sd8388607;
    if (rounded < -64'sd8388608) rounded = -64'sd8388608;
    emit = (frames_seen + 1 >= L - L / 2);
    if (last) begin
      bin_pos = '0;
      if (frames_seen < 6'd63) frames_seen++;
    end else begin
      bin_pos++;
    end
    if (emit) begin
      r.value     = rounded[23:0];
      r.bin       = slot[7:0];
      r.frame_end = last;
      pending_smoothed = {pending_smoothed, r};
    end
  endfunction

  function void check_smoothed(logic signed [23:0] value, logic [7:0] bin, logic fe);
    smoothed_t want;
    checked++;
    if (pending_smoothed.size() == 0) begin
      $error("result with nothing expected: filtered_value %0d bin_index %0d", value, bin);
      mismatches++;
      return;
    end
    want = pending_smoothed.pop_front();
    if (value !== want.value) begin
      $error("filtered_value: expected %0d, got %0d", want.value, value);
      mismatches++;
    end
    if (bin !== want.bin) begin
      $error("bin_index: expected %0d, got %0d", want.bin, bin);
      mismatches++;
    end
    if (fe !== want.frame_end) begin
      $error("frame_end: expected %0d, got %0d", want.frame_end, fe);
      mismatches++;
    end
  endfunction
endclass

module tb;
  import fwc_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 64;    // longest sample has 32 taps
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 1250;

  localparam logic signed [23:0] VAL_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] VAL_MIN = 24'sh800000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [0:0]         cfg_idx_i;
  logic [8:0]         cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               mode_i;
  logic signed [23:0] sample_value_i;
  logic               sample_missing_i;
  logic [4:0]         coef_index_i;
  logic [16:0]        coef_value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [23:0] filtered_value_o;
  logic [7:0]         bin_index_o;
  logic               frame_end_o;

  framewise_window_convolution_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .sample_value_i   (sample_value_i),
    .sample_missing_i (sample_missing_i),
    .coef_index_i     (coef_index_i),
    .coef_value_i     (coef_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .filtered_value_o (filtered_value_o),
    .bin_index_o      (bin_index_o),
    .frame_end_o      (frame_end_o)
  );

  bin_smoother_sb smoother;

  int cycle_count = 0;
  int burst_left  = 0;
  int items_sent  = 0;
  int samples     = 0;
  int loads       = 0;
  int settings    = 0;
  bit weight_loaded [32];

  // receiver side state
  bit hold_req;
  int hold_left    = 0;
  int stretch_left = 0;
  int stall_style  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // watchdog: a hung handshake ends the run here
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("** framewise_window_convolution_core: FAILED **");
    $finish;
  end

  // receiver: stretches of random stall styles, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req    <= 1'b0;
      out_stall_i <= 1'b1;
    end else begin
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(16, 160);
        stall_style  = $urandom_range(0, 3);
      end
      stretch_left--;
      case (stall_style)
        0: out_stall_i <= 1'b0;                          // free flowing
        1: out_stall_i <= ($urandom_range(0, 3) == 0);   // light
        2: out_stall_i <= ($urandom_range(0, 3) != 0);   // heavy
        default: out_stall_i <= ((stretch_left % 8) < 5); // periodic
      endcase
    end
  end

  // every result transfer goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      smoother.check_smoothed(filtered_value_o, bin_index_o, frame_end_o);
  end

  // one input transfer; the sender idles between bursts of random length
  task automatic offer(input smooth_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i       <= 1'b1;
    mode_i           <= it.mode;
    sample_value_i   <= it.value;
    sample_missing_i <= it.missing;
    coef_index_i     <= it.coef_idx;
    coef_value_i     <= it.coef_val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    smoother.note_item(it);
    items_sent++;
  endtask

  // unused fields carry random bits so the core must ignore them
  task automatic send_bin(input logic signed [23:0] v, input bit miss);
    smooth_item_t it;
    it.mode     = MODE_SAMPLE;
    it.value    = v;
    it.missing  = miss;
    it.coef_idx = 5'($urandom);
    it.coef_val = 17'($urandom);
    offer(it);
    samples++;
  endtask

  task automatic send_weight(input int unsigned idx, input logic [16:0] w);
    smooth_item_t it;
    it.mode     = MODE_COEF;
    it.value    = 24'($urandom);
    it.missing  = 1'($urandom);
    it.coef_idx = 5'(idx);
    it.coef_val = w;
    offer(it);
    weight_loaded[idx] = 1'b1;
    loads++;
  endtask

  function automatic logic signed [23:0] pick_value();
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return -24'sd1;
      4: return 24'($urandom_range(0, 255));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [16:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 17'd65536;
      2: return 17'($urandom_range(0, 131071));
      default: return 17'($urandom_range(0, 16384));
    endcase
  endfunction

  // stop sending and wait until every predicted result has come out
  task automatic settle();
    in_valid_i <= 1'b0;
    while (smoother.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // both registers, written back to back while the core is idle
  task automatic configure(input int unsigned L, input int unsigned N);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_WINDOW_LENGTH;
    cfg_data_i <= 9'(L);
    @(posedge clk_i);
    smoother.set_reg(CFG_WINDOW_LENGTH, 9'(L));
    cfg_idx_i  <= CFG_BINS_PER_FRAME;
    cfg_data_i <= 9'(N);
    @(posedge clk_i);
    smoother.set_reg(CFG_BINS_PER_FRAME, 9'(N));
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  // never let a tap read a weight that was not loaded
  task automatic ensure_weights();
    for (int i = 0; i < smoother.taps(); i++)
      if (!weight_loaded[i]) send_weight(i, pick_weight());
  endtask

  // a run of bin samples with the odd weight reload mixed in; flush runs are zeros
  task automatic send_run(input int count, input bit flush);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0) send_weight($urandom_range(0, 31), pick_weight());
      if (flush) send_bin('0, 1'b0);
      else send_bin(pick_value(), ($urandom_range(0, 9) == 0));
    end
  endtask

  initial begin
    int unsigned L, N, eff, nb, nframes;
    int          phase;
    int          start_count;

    smoother = new();
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_WINDOW_LENGTH;
    cfg_data_i       <= '0;
    in_valid_i       <= 1'b0;
    mode_i           <= MODE_SAMPLE;
    sample_value_i   <= '0;
    sample_missing_i <= 1'b0;
    coef_index_i     <= '0;
    coef_value_i     <= '0;
    out_stall_i      <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: three taps over two bins, results from the second frame on
    configure(3, 2);
    send_weight(0, 17'd65536);
    send_weight(1, 17'd65536);
    send_weight(2, 17'd65536);
    send_bin(VAL_MAX, 1'b0);          // startup frame, no result
    send_bin(VAL_MIN, 1'b0);
    send_bin(VAL_MAX, 1'b0);          // sums clip at both ends
    send_bin(VAL_MIN, 1'b0);
    send_bin(VAL_MAX, 1'b1);          // missing incoming with a live value
    send_bin(VAL_MIN, 1'b1);
    send_bin(VAL_MAX, 1'b1);
    send_bin(VAL_MIN, 1'b1);
    send_bin(24'sd5, 1'b1);           // whole window missing gives zero
    send_bin(-24'sd5, 1'b1);
    send_weight(0, 17'd0);
    send_weight(1, 17'h1FFFF);        // weight above one is kept as given
    send_weight(2, 17'd32768);
    send_bin(24'sd1, 1'b0);           // exact halves round up
    send_bin(-24'sd1, 1'b0);
    // leave the bin position at 3, then shrink the frame under it
    configure(3, 4);
    send_bin(pick_value(), 1'b0);
    send_bin(pick_value(), 1'b0);
    send_bin(pick_value(), 1'b0);
    configure(0, 2);                  // zero length acts as one tap
    send_weight(0, 17'd40000);
    send_bin(pick_value(), 1'b0);     // position past the end closes the frame
    send_bin(pick_value(), 1'b0);

    // random phases: mostly whole frames, sometimes a flush or a ragged tail
    start_count = items_sent;
    phase = 0;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0: L = 0;
        1: L = 1;
        2: L = 32;
        3: L = $urandom_range(33, 63);
        default: L = $urandom_range(2, 12);
      endcase
      if (phase == 0) L = $urandom_range(0, 2);
      // wide frames only with short windows, to keep startup cheap
      if (phase == 0) N = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
      else if (L > 16) N = $urandom_range(1, 3);
      else if ($urandom_range(0, 7) == 0) N = 0;
      else N = $urandom_range(1, 8);
      if (phase == 2) N = $urandom_range(4, 8);
      configure(L, N);
      ensure_weights();
      eff = smoother.taps();
      nb  = smoother.frame_bins();
      // receiver holds off while the sender keeps offering, so the core backs up
      if (phase == 2) hold_req <= 1'b1;
      nframes = (phase == 0) ? 1 : eff - eff / 2 - 1 + $urandom_range(1, 4);
      send_run(nframes * nb, 1'b0);
      if ($urandom_range(0, 1) == 1) send_run(((eff - 1) / 2) * nb, 1'b1);
      if (nb > 1 && $urandom_range(0, 2) == 0) send_run($urandom_range(1, nb - 1), 1'b0);
      phase++;
    end

    settle();
    $display("covered %0d bin samples and %0d weight loads over %0d window settings",
             samples, loads, settings);
    $display("%0d results compared, %0d mismatches", smoother.checked, smoother.mismatches);
    if (smoother.mismatches == 0) begin
      $display("** framewise_window_convolution_core: PASSED **");
    end else begin
      $display("** framewise_window_convolution_core: FAILED **");
    end
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/fwc_pkg.sv
hw/rtl/fwc_ram.sv
hw/rtl/fwc_mac.sv
hw/rtl/framewise_window_convolution_core.sv
tb/sv/tb.sv
